>>> hdl/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg
// Shared types and constants of the target lock tracker.
// ----------------------------------------------------------------------------
package tlt_pkg;

    localparam int unsigned CNT_W    = 16;
    localparam int unsigned RAD_W    = 10;
    localparam int unsigned PIX_W    = 11;
    localparam int unsigned OFS_W    = 14;
    localparam int unsigned AGE_W    = 10;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned CFG_IX_W = 3;
    localparam int unsigned CFG_D_W  = 16;
    localparam int unsigned IN_W     = 48;
    localparam int unsigned OUT_W    = 80;

    localparam logic [AGE_W-1:0] TIMEOUT_TICKS = AGE_W'(500);
    localparam logic [AGE_W-1:0] AGE_MAX       = '1;
    localparam logic [CNT_W-1:0] CNT_MAX       = '1;

    localparam logic [CNT_W-1:0] FRAMES_TO_LOCK_RST   = CNT_W'(5);
    localparam logic [CNT_W-1:0] FRAMES_TO_SEARCH_RST = CNT_W'(10);
    localparam logic [CNT_W-1:0] FRAMES_TO_LOST_RST   = CNT_W'(100);
    localparam logic [RAD_W-1:0] DEFAULT_RADIUS_RST   = RAD_W'(10);
    localparam logic [RAD_W-1:0] MAX_RADIUS_RST       = RAD_W'(50);
    localparam logic [RAD_W-1:0] RADIUS_STEP_RST      = RAD_W'(5);
    localparam logic [PIX_W-1:0] FRAME_WIDTH_RST      = PIX_W'(1280);
    localparam logic [PIX_W-1:0] FRAME_HEIGHT_RST     = PIX_W'(720);

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE      = 3'd0,
        MODE_LOCKING   = 3'd1,
        MODE_TRACKING  = 3'd2,
        MODE_SEARCHING = 3'd3,
        MODE_LOST      = 3'd4
    } mode_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE   = 3'd0,
        CMD_DETECTION = 3'd1,
        CMD_MISS      = 3'd2,
        CMD_TICK      = 3'd3,
        CMD_SET_MODE  = 3'd4,
        CMD_RESET     = 3'd5
    } cmd_t;

    typedef enum logic [CFG_IX_W-1:0] {
        REG_FRAMES_TO_LOCK   = 3'd0,
        REG_FRAMES_TO_SEARCH = 3'd1,
        REG_FRAMES_TO_LOST   = 3'd2,
        REG_DEFAULT_RADIUS   = 3'd3,
        REG_MAX_RADIUS       = 3'd4,
        REG_RADIUS_STEP      = 3'd5,
        REG_FRAME_WIDTH      = 3'd6,
        REG_FRAME_HEIGHT     = 3'd7
    } cfg_reg_t;

endpackage

>>> hdl/target_lock_tracker_core.sv
// ----------------------------------------------------------------------------
// target_lock_tracker_core
// Target lock mode machine with saturating frame counters and search radius.
// ----------------------------------------------------------------------------
// Each input item is one event (kind on s_tuser) and yields exactly one result
// item, the tracker state after that event. The state update is a single
// combinational pass between the state registers, so one item is taken every
// clock cycle while s_tready is high; a result is registered in the output
// register, or in the skid register while that is held. This two-entry buffer
// lets the slave side keep accepting while a result waits; s_tready drops
// only when both entries are full. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module target_lock_tracker_core
    import tlt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_IX_W-1:0] cfg_index,
    input  logic [CFG_D_W-1:0]  cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // box_x[10:0], box_y[21:11], box_width[32:22], box_height[43:33],
    // new_mode[46:44], zero[47]
    input  logic [IN_W-1:0]     s_tdata,
    // command[2:0]
    input  logic [CMD_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // mode[2:0], searching_flag[3], target_valid[4], scan_radius[14:5],
    // centre_dx[28:15], centre_dy[42:29], visible_count[58:43],
    // lost_count[74:59], zero[79:75]
    output logic [OUT_W-1:0]    m_tdata
);

    logic [CNT_W-1:0] frames_to_lock_reg, frames_to_search_reg, frames_to_lost_reg;
    logic [RAD_W-1:0] default_radius_reg, max_radius_reg, radius_step_reg;
    logic [PIX_W-1:0] frame_width_reg, frame_height_reg;

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] visible_reg, visible_next;
    logic [CNT_W-1:0] lost_reg, lost_next;
    logic [CNT_W-1:0] phase_reg, phase_next;
    logic [RAD_W-1:0] radius_reg, radius_next;
    logic             searching_reg, searching_next;
    logic             valid_reg, valid_next;
    logic [AGE_W-1:0] age_reg, age_next;
    logic [OFS_W-1:0] centre_dx_reg, centre_dx_next;
    logic [OFS_W-1:0] centre_dy_reg, centre_dy_next;

    logic             out_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0] out_data_reg, skid_data_reg;

    logic [PIX_W-1:0] box_x, box_y, box_w, box_h;
    logic [MODE_W-1:0] new_mode;
    logic             in_fire, out_fire;
    logic [OFS_W-1:0] box_ofs_x, box_ofs_y;
    logic [CNT_W-1:0] visible_inc, lost_inc, age_pad;
    logic [CNT_W:0]   phase_inc;
    logic             wrap;
    logic [RAD_W-1:0] radius_grown;
    logic [RAD_W:0]   radius_sum;
    logic [AGE_W-1:0] age_inc;
    logic [OUT_W-1:0] result;

    assign box_x    = s_tdata[10:0];
    assign box_y    = s_tdata[21:11];
    assign box_w    = s_tdata[32:22];
    assign box_h    = s_tdata[43:33];
    assign new_mode = s_tdata[46:44];

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_to_lock_reg   <= FRAMES_TO_LOCK_RST;
            frames_to_search_reg <= FRAMES_TO_SEARCH_RST;
            frames_to_lost_reg   <= FRAMES_TO_LOST_RST;
            default_radius_reg   <= DEFAULT_RADIUS_RST;
            max_radius_reg       <= MAX_RADIUS_RST;
            radius_step_reg      <= RADIUS_STEP_RST;
            frame_width_reg      <= FRAME_WIDTH_RST;
            frame_height_reg     <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAMES_TO_LOCK:   frames_to_lock_reg   <= cfg_data;
                REG_FRAMES_TO_SEARCH: frames_to_search_reg <= cfg_data;
                REG_FRAMES_TO_LOST:   frames_to_lost_reg   <= cfg_data;
                REG_DEFAULT_RADIUS:   default_radius_reg   <= cfg_data[RAD_W-1:0];
                REG_MAX_RADIUS:       max_radius_reg       <= cfg_data[RAD_W-1:0];
                REG_RADIUS_STEP:      radius_step_reg      <= cfg_data[RAD_W-1:0];
                REG_FRAME_WIDTH:      frame_width_reg      <= cfg_data[PIX_W-1:0];
                REG_FRAME_HEIGHT:     frame_height_reg     <= cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        box_ofs_x = {box_x, 1'b0} + OFS_W'(box_w) - OFS_W'(frame_width_reg);
        box_ofs_y = {box_y, 1'b0} + OFS_W'(box_h) - OFS_W'(frame_height_reg);
        visible_inc = (visible_reg == CNT_MAX) ? visible_reg : visible_reg + 1'b1;
        lost_inc    = (lost_reg == CNT_MAX) ? lost_reg : lost_reg + 1'b1;
        phase_inc   = {1'b0, phase_reg} + 1'b1;
        wrap        = phase_inc >= {1'b0, frames_to_search_reg};
        age_inc     = (age_reg == AGE_MAX) ? age_reg : age_reg + 1'b1;
        age_pad     = CNT_W'(age_inc);
        radius_sum  = {1'b0, radius_reg} + {1'b0, radius_step_reg};
        if (radius_reg < max_radius_reg)
        begin
            radius_grown = (radius_sum < {1'b0, max_radius_reg}) ?
                           radius_sum[RAD_W-1:0] : max_radius_reg;
        end
        else
        begin
            radius_grown = radius_reg;
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        visible_next   = visible_reg;
        lost_next      = lost_reg;
        phase_next     = phase_reg;
        radius_next    = radius_reg;
        searching_next = searching_reg;
        valid_next     = valid_reg;
        age_next       = age_reg;
        centre_dx_next = centre_dx_reg;
        centre_dy_next = centre_dy_reg;
        case (cmd_t'(s_tuser))
            CMD_ACQUIRE:
            begin
                centre_dx_next = box_ofs_x;
                centre_dy_next = box_ofs_y;
                age_next       = '0;
                valid_next     = 1'b1;
                mode_next      = MODE_LOCKING;
                visible_next   = '0;
                lost_next      = '0;
                phase_next     = '0;
                radius_next    = default_radius_reg;
                searching_next = 1'b0;
            end
            CMD_DETECTION:
            begin
                centre_dx_next = box_ofs_x;
                centre_dy_next = box_ofs_y;
                age_next       = '0;
                valid_next     = 1'b1;
                visible_next   = visible_inc;
                lost_next      = '0;
                phase_next     = '0;
                if ((mode_reg == MODE_LOCKING && visible_inc >= frames_to_lock_reg) ||
                    mode_reg == MODE_SEARCHING)
                begin
                    mode_next      = MODE_TRACKING;
                    searching_next = 1'b0;
                    radius_next    = default_radius_reg;
                end
            end
            CMD_MISS:
            begin
                lost_next    = lost_inc;
                visible_next = '0;
                phase_next   = wrap ? '0 : phase_inc[CNT_W-1:0];
                if (mode_reg == MODE_TRACKING || mode_reg == MODE_LOCKING)
                begin
                    if (lost_inc >= frames_to_search_reg)
                    begin
                        mode_next      = MODE_SEARCHING;
                        searching_next = 1'b1;
                        radius_next    = radius_grown;
                    end
                end
                else if (mode_reg == MODE_SEARCHING)
                begin
                    if (wrap && lost_inc >= frames_to_search_reg)
                    begin
                        radius_next = radius_grown;
                    end
                    if (lost_inc >= frames_to_lost_reg)
                    begin
                        mode_next      = MODE_LOST;
                        searching_next = 1'b0;
                    end
                end
            end
            CMD_TICK:
            begin
                age_next = age_inc;
                if (mode_reg != MODE_IDLE && valid_reg &&
                    age_pad > CNT_W'(TIMEOUT_TICKS))
                begin
                    valid_next = 1'b0;
                end
            end
            CMD_SET_MODE:
            begin
                if (new_mode <= MODE_LOST)
                begin
                    mode_next = mode_t'(new_mode);
                end
            end
            CMD_RESET:
            begin
                mode_next      = MODE_IDLE;
                visible_next   = '0;
                lost_next      = '0;
                phase_next     = '0;
                radius_next    = default_radius_reg;
                searching_next = 1'b0;
                valid_next     = 1'b0;
                age_next       = '0;
                centre_dx_next = '0;
                centre_dy_next = '0;
            end
            default: ;
        endcase
    end

    assign result = {5'b0, lost_next, visible_next, centre_dy_next, centre_dx_next,
                     radius_next, valid_next, searching_next, mode_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            visible_reg   <= '0;
            lost_reg      <= '0;
            phase_reg     <= '0;
            radius_reg    <= DEFAULT_RADIUS_RST;
            searching_reg <= 1'b0;
            valid_reg     <= 1'b0;
            age_reg       <= '0;
            centre_dx_reg <= '0;
            centre_dy_reg <= '0;
        end
        else if (in_fire)
        begin
            mode_reg      <= mode_next;
            visible_reg   <= visible_next;
            lost_reg      <= lost_next;
            phase_reg     <= phase_next;
            radius_reg    <= radius_next;
            searching_reg <= searching_next;
            valid_reg     <= valid_next;
            age_reg       <= age_next;
            centre_dx_reg <= centre_dx_next;
            centre_dy_reg <= centre_dy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg  <= skid_valid_reg || in_fire;
                skid_valid_reg <= 1'b0;
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        if (in_fire && out_valid_reg && !out_fire)
        begin
            skid_data_reg <= result;
        end
    end

endmodule
